/* rtl/mrtu_pkg.sv */
`timescale 1ns / 1ps

package mrtu_pkg;

  // frame buffer depth and derived widths
  localparam int FRAME_BYTES = 256;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int          MIN_LEN  = 4;

  // configuration port
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int ADDR_LSB = 2;
  localparam logic [PADDR_W-ADDR_LSB-1:0] REG_LISTEN_ADDR = '0;
  localparam logic [7:0] LISTEN_ADDR_RST = 8'd1;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_EOF  = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    FS_VALID     = 3'd0,
    FS_BROADCAST = 3'd1,
    FS_BAD       = 3'd2,
    FS_IGNORED   = 3'd3,
    FS_NO_FRAME  = 3'd4
  } frame_status_t;

  typedef enum logic {
    RK_VERDICT = 1'b0,
    RK_READ    = 1'b1
  } result_kind_t;

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_ADDR = 3'b010,
    M_SKIP = 3'b100
  } rx_mode_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CRC  = 4'b0010,
    S_READ = 4'b0100,
    S_PUSH = 4'b1000
  } seq_state_t;

endpackage

/* rtl/modbus_rtu_frame_receiver.sv */
`timescale 1ns / 1ps

// channel | handshake            | payload
// --------+----------------------+---------------------------------------------------
// in      | in_valid / in_stall  | operation, rx_byte, read_index
// out     | out_valid / out_stall| result_kind, frame_status, payload_length, read_data
// cfg     | apb (psel, penable)  | paddr, pwdata, prdata
//
// a stored byte is accepted, then run through the bit-serial crc shifter
// a read: accept, frame store read, output load; end of frame: accept, output load
// the store takes each opening byte, and addressed bytes while room is left; reads are registered
// rst is synchronous; the frame store is not cleared, never written entries read as garbage
// a result waits in the output register; bytes are still taken while it is stalled,
// an item that produces a result waits in S_PUSH until the output register frees

module modbus_rtu_frame_receiver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     operation,
  input  logic [7:0]                     rx_byte,
  input  logic [7:0]                     read_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           result_kind,
  output logic [2:0]                     frame_status,
  output logic [7:0]                     payload_length,
  output logic [7:0]                     read_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mrtu_pkg::PADDR_W-1:0]   paddr,
  input  logic [mrtu_pkg::PDATA_W-1:0]   pwdata,
  output logic [mrtu_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import mrtu_pkg::*;

  logic [7:0]       listening_address;
  seq_state_t       state;
  rx_mode_t         mode;
  logic [CNT_W-1:0] byte_count;
  logic [15:0]      crc;
  logic [2:0]       bit_cnt;
  logic             addr_zero;

  logic             pend_kind;
  logic [2:0]       pend_status;
  logic [7:0]       pend_len;
  logic             pend_rzero;

  logic [7:0]       frame_store [FRAME_BYTES];
  logic [7:0]       mem_q;
  logic             mem_we;
  logic             mem_re;
  logic [ADDR_W-1:0] mem_waddr;

  logic             in_fire;
  logic             push_fire;
  logic             cfg_wr;
  logic             buf_full;
  logic             read_in_range;
  logic [15:0]      crc_shift;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[PADDR_W-1:ADDR_LSB] == REG_LISTEN_ADDR)
                    ? PDATA_W'(listening_address) : '0;

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign push_fire = (state == S_PUSH) && (!out_valid || !out_stall);

  assign buf_full      = (byte_count >= CNT_W'(FRAME_BYTES));
  assign read_in_range = ({24'd0, read_index} < 32'(FRAME_BYTES));
  assign crc_shift     = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);

  // store the byte at 0 when a frame opens, else append while the frame is addressed and room is left
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    if (in_fire && operation == OP_BYTE) begin
      if (mode == M_IDLE) begin
        mem_we = 1'b1;
      end else if (mode == M_ADDR && !buf_full) begin
        mem_we    = 1'b1;
        mem_waddr = byte_count[ADDR_W-1:0];
      end
    end
  end

  assign mem_re = in_fire && (operation == OP_READ);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= rx_byte;
    end
    if (mem_re) begin
      mem_q <= frame_store[read_index[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      listening_address <= LISTEN_ADDR_RST;
    end else if (cfg_wr && paddr[PADDR_W-1:ADDR_LSB] == REG_LISTEN_ADDR) begin
      listening_address <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= M_IDLE;
      byte_count <= '0;
      crc        <= CRC_INIT;
      bit_cnt    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (operation)
              OP_BYTE: begin
                if (mode == M_IDLE) begin
                  byte_count <= CNT_W'(1);
                  crc        <= CRC_INIT ^ {8'd0, rx_byte};
                  addr_zero  <= (rx_byte == 8'd0);
                  mode       <= (rx_byte == listening_address || rx_byte == 8'd0)
                                ? M_ADDR : M_SKIP;
                  bit_cnt    <= '0;
                  state      <= S_CRC;
                end else if (mode == M_ADDR) begin
                  if (buf_full) begin
                    mode <= M_SKIP;
                  end else begin
                    byte_count <= byte_count + CNT_W'(1);
                    crc        <= crc ^ {8'd0, rx_byte};
                    bit_cnt    <= '0;
                    state      <= S_CRC;
                  end
                end
              end
              OP_EOF: begin
                pend_kind <= RK_VERDICT;
                pend_len  <= 8'd0;
                if (mode == M_ADDR) begin
                  if (byte_count > CNT_W'(MIN_LEN) && crc == 16'd0) begin
                    pend_status <= addr_zero ? FS_BROADCAST : FS_VALID;
                    pend_len    <= 8'(byte_count - CNT_W'(2));
                  end else begin
                    pend_status <= FS_BAD;
                  end
                end else if (mode == M_SKIP) begin
                  pend_status <= FS_IGNORED;
                end else begin
                  pend_status <= FS_NO_FRAME;
                end
                mode  <= M_IDLE;
                crc   <= CRC_INIT;
                state <= S_PUSH;
              end
              OP_READ: begin
                pend_kind   <= RK_READ;
                pend_status <= FS_VALID;
                pend_len    <= 8'd0;
                pend_rzero  <= !read_in_range;
                state       <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_CRC: begin
          crc     <= crc_shift;
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (push_fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded only when the output register is free
  always_ff @(posedge clk) begin
    if (push_fire) begin
      result_kind    <= pend_kind;
      frame_status   <= pend_status;
      payload_length <= pend_len;
      read_data      <= (pend_kind == RK_READ && !pend_rzero) ? mem_q : 8'd0;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(FRAME_BYTES))
    else $error("byte count beyond frame buffer");

  a_crc_len: assert property (@(posedge clk) disable iff (rst)
    state == S_CRC && bit_cnt == 3'd7 |=> state == S_IDLE)
    else $error("crc shifter ran past eight steps");

  a_eof_reset: assert property (@(posedge clk) disable iff (rst)
    in_fire && operation == OP_EOF |=> mode == M_IDLE && crc == CRC_INIT && state == S_PUSH)
    else $error("end of frame did not return receiver to idle");

  a_append: assert property (@(posedge clk) disable iff (rst)
    in_fire && operation == OP_BYTE && mode == M_ADDR && !buf_full
    |=> byte_count == $past(byte_count) + CNT_W'(1))
    else $error("stored byte not counted");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mrtu_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE       = 20;
  localparam int REPLY_WAIT   = 4000;
  localparam int PHASE_ITEMS  = 260;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] LISTEN_PADDR = {REG_LISTEN_ADDR, {ADDR_LSB{1'b0}}};

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx;
    logic [7:0] idx;
  } rx_item_t;

  typedef struct packed {
    result_kind_t  kind;
    frame_status_t status;
    logic [7:0]    len;
    logic [7:0]    data;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic         in_valid   = 1'b0;
  logic         in_stall;
  logic [1:0]   operation  = 2'd0;
  logic [7:0]   rx_byte    = 8'd0;
  logic [7:0]   read_index = 8'd0;
  logic         out_valid;
  logic         out_stall  = 1'b0;
  logic         result_kind;
  logic [2:0]   frame_status;
  logic [7:0]   payload_length;
  logic [7:0]   read_data;
  logic         psel    = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr  = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic         pready;

  rx_item_t rx_items[$];
  reply_t   expected_replies[$];
  logic [7:0] frame_bytes[$];

  int errors        = 0;
  int cycles        = 0;
  int items_made    = 0;
  int store_fill    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // receiver mirror
  logic [7:0]  listen_addr = LISTEN_ADDR_RST;
  rx_mode_t    m_mode  = M_IDLE;
  logic [8:0]  m_count = '0;
  logic [15:0] m_crc   = CRC_INIT;
  logic [7:0]  m_store [FRAME_BYTES];

  modbus_rtu_frame_receiver u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .rx_byte        (rx_byte),
    .read_index     (read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .frame_status   (frame_status),
    .payload_length (payload_length),
    .read_data      (read_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void receive_item(input rx_item_t it);
    reply_t r;
    r.kind   = RK_VERDICT;
    r.status = FS_VALID;
    r.len    = 8'd0;
    r.data   = 8'd0;
    case (it.op)
      OP_BYTE: begin
        if (m_mode == M_IDLE) begin
          m_store[0] = it.rx;
          m_count    = 9'd1;
          m_crc      = crc16_byte(CRC_INIT, it.rx);
          m_mode     = (it.rx == listen_addr || it.rx == 8'd0) ? M_ADDR : M_SKIP;
        end else if (m_mode == M_ADDR) begin
          // buffer full: the rest of the frame is dropped
          if (m_count >= FRAME_BYTES) begin
            m_mode = M_SKIP;
          end else begin
            m_store[m_count[7:0]] = it.rx;
            m_count = m_count + 9'd1;
            m_crc   = crc16_byte(m_crc, it.rx);
          end
        end
      end
      OP_EOF: begin
        if (m_mode == M_ADDR) begin
          // crc over frame plus trailing crc is zero when it matches
          if (m_count > 9'(MIN_LEN) && m_crc == 16'd0) begin
            r.status = (m_store[0] == 8'd0) ? FS_BROADCAST : FS_VALID;
            r.len    = 8'(m_count - 9'd2);
          end else begin
            r.status = FS_BAD;
          end
        end else if (m_mode == M_SKIP) begin
          r.status = FS_IGNORED;
        end else begin
          r.status = FS_NO_FRAME;
        end
        m_mode = M_IDLE;
        m_crc  = CRC_INIT;
        expected_replies.push_back(r);
      end
      OP_READ: begin
        r.kind = RK_READ;
        r.data = m_store[it.idx];
        expected_replies.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin : drive
    rx_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) receive_item({operation, rx_byte, read_index});
      if (!in_valid || !in_stall) begin
        if (rx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = rx_items.pop_front();
          operation  <= nxt.op;
          rx_byte    <= nxt.rx;
          read_index <= nxt.idx;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          if (errors < 10)
            $display("unexpected transaction: kind %0d status %0d len %0d data %02h",
                     result_kind, frame_status, payload_length, read_data);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (result_kind !== want.kind || frame_status !== want.status ||
              payload_length !== want.len || read_data !== want.data) begin
            if (errors < 10)
              $display("mismatch: expected %0d %0d %0d %02h, got %0d %0d %0d %02h",
                       want.kind, want.status, want.len, want.data,
                       result_kind, frame_status, payload_length, read_data);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_raw(input rx_item_t it);
    rx_items.push_back(it);
    if (it.op != OP_UNUSED) items_made++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_raw({OP_BYTE, b, 8'($urandom)});
  endtask

  task automatic push_eof();
    push_raw({OP_EOF, 8'($urandom), 8'($urandom)});
  endtask

  task automatic push_read(input logic [7:0] i);
    push_raw({OP_READ, 8'($urandom), i});
  endtask

  // sends frame_bytes, optionally with crc and trailing bytes, then end of frame
  task automatic send_frame(input bit with_crc, input bit corrupt, input int extra);
    logic [15:0] c;
    int n;
    c = CRC_INIT;
    foreach (frame_bytes[i]) begin
      c = crc16_byte(c, frame_bytes[i]);
      push_byte(frame_bytes[i]);
    end
    if (with_crc) begin
      if (corrupt) c = c ^ 16'(1 << $urandom_range(15));
      push_byte(c[7:0]);
      push_byte(c[15:8]);
    end
    repeat (extra) push_byte(8'($urandom));
    n = frame_bytes.size() + (with_crc ? 2 : 0) + extra;
    if (n > FRAME_BYTES) n = FRAME_BYTES;
    // store entries known to be written, so reads never hit stale entries
    if (frame_bytes[0] == listen_addr || frame_bytes[0] == 8'd0) begin
      if (n > store_fill) store_fill = n;
    end else if (store_fill < 1) begin
      store_fill = 1;
    end
    push_eof();
  endtask

  task automatic write_listen(input logic [7:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LISTEN_PADDR;
    pwdata  <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    listen_addr = v;
  endtask

  task automatic check_listen_reg();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LISTEN_PADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, listen_addr}) begin
      if (errors < 10)
        $display("listen address readback: expected %02h, got %08h", listen_addr, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    int k;
    while (rx_items.size() != 0 || in_valid) @(posedge clk);
    k = 0;
    while (expected_replies.size() != 0 && k < REPLY_WAIT) begin
      @(posedge clk);
      k++;
    end
    if (expected_replies.size() != 0) begin
      $display("%0d expected transactions never arrived", expected_replies.size());
      errors += expected_replies.size();
      expected_replies.delete();
    end
    // bytes still in the crc shifter give no transaction to wait on
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic gen_traffic(input int want);
    int start, sel, len, pick;
    logic [1:0] op;
    start = items_made;
    while (items_made - start < want) begin
      sel  = $urandom_range(99);
      pick = $urandom_range(9);
      frame_bytes.delete();
      if (pick < 5)      frame_bytes.push_back(listen_addr);
      else if (pick < 7) frame_bytes.push_back(8'd0);
      else               frame_bytes.push_back(8'($urandom));
      // rare long frames straddle the buffer size
      if ($urandom_range(119) == 0) len = $urandom_range(251, 255);
      else                          len = $urandom_range(0, 9);
      repeat (len) frame_bytes.push_back(8'($urandom));
      if (sel < 70) begin
        send_frame(1'b1, $urandom_range(9) == 0, ($urandom_range(19) == 0) ? 1 : 0);
      end else if (sel < 82) begin
        send_frame(1'b0, 1'b0, 0);
      end else if (sel < 92) begin
        if (sel < 85) push_eof();
        repeat ($urandom_range(1, 4)) push_read(8'($urandom_range(store_fill - 1)));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          op = 2'($urandom_range(3));
          if (op == OP_READ) push_read(8'($urandom_range(store_fill - 1)));
          else               push_raw({op, 8'($urandom), 8'($urandom)});
        end
        push_eof();
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] next_listen;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    check_listen_reg();

    // directed
    push_eof();
    push_raw({OP_UNUSED, 8'hFF, 8'hFF});
    frame_bytes = '{8'h01, 8'h03, 8'h00, 8'h6B, 8'h00, 8'h03};
    send_frame(1'b1, 1'b0, 0);
    push_read(8'd0);
    push_read(8'd5);
    frame_bytes = '{8'h00, 8'h06, 8'h00, 8'h01, 8'h00, 8'hFF};
    send_frame(1'b1, 1'b0, 0);
    frame_bytes = '{8'h01, 8'h03};
    send_frame(1'b1, 1'b0, 0);
    frame_bytes = '{8'h01, 8'h03, 8'h07};
    send_frame(1'b1, 1'b0, 0);
    frame_bytes = '{8'h01, 8'h10, 8'h00, 8'h01};
    send_frame(1'b1, 1'b1, 0);
    frame_bytes = '{8'hFF, 8'h03, 8'h00, 8'h00};
    send_frame(1'b1, 1'b0, 0);
    // full buffer plus one more byte: overflow
    frame_bytes.delete();
    frame_bytes.push_back(8'h01);
    for (int i = 1; i < FRAME_BYTES - 2; i++) frame_bytes.push_back(8'(i) ^ 8'hA5);
    send_frame(1'b1, 1'b0, 1);
    push_read(8'hFF);
    push_read(8'h80);
    push_read(8'h7F);
    push_eof();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          next_listen   = 8'd247;
        end
        1: begin
          send_idle_pct = 86;
          stall_pct     = 0;
          next_listen   = 8'd1;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 86;
          next_listen   = 8'($urandom_range(2, 246));
        end
        default: begin
          send_idle_pct = 6;
          stall_pct     = 6;
          next_listen   = 8'($urandom_range(1, 247));
        end
      endcase
      write_listen(next_listen);
      check_listen_reg();
      gen_traffic(PHASE_ITEMS);
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
